// File: design/frwm_pkg.sv
// Package for the frame rate window meter: field widths, status and op codes,
// the Q16.16 nanosecond scale and default parameter values.
// No dependencies.
package frwm_pkg;

    localparam int TIME_W     = 62;
    localparam int FPS_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int SF_W       = 4;
    localparam int NS_Q16_W   = 46;

    localparam int WINDOW_DEF      = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [SF_W-1:0]     SF_RESET     = 4'd5;
    localparam logic [NS_Q16_W-1:0] NS_PER_S_Q16 = 46'd65536000000000;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

endpackage

// File: design/frame_rate_window_meter_core.sv
// Top level of the frame rate window meter: front end, queue, back end and
// the stall factor register. Uses frwm_pkg, frwm_front, frwm_queue, frwm_back.
//
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   s_tuser = op, s_tdata = time_ns
//  m_       out  m_tvalid / m_tready   m_tuser = status, m_tdata = fps_q16, stamps_held
//  cfg_     in   cfg_valid / cfg_ready cfg_data = stall_factor
//
// A record item is taken every cycle unless a query waits on a full queue; it yields no item.
// An OK query gets its rate from the one-bit-per-cycle restoring divider in the back end.
// Queries are queued, so records keep flowing while the divider is busy.
// Reset clears the ring counters, queue and output; stall_factor returns to 5.
// A stalled m_ channel holds the result and, once the queue fills, s_tready.
module frame_rate_window_meter_core #(
    parameter int WINDOW      = frwm_pkg::WINDOW_DEF,
    parameter int QUEUE_DEPTH = frwm_pkg::QUEUE_DEPTH_DEF,
    parameter int FW          = $clog2(WINDOW + 1),
    parameter int M_TDATA_W   = ((frwm_pkg::FPS_W + FW + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // time_ns[61:0], zero pad
    input  logic [0:0]                    s_tuser,  // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,  // fps_q16[31:0], stamps_held, zero pad
    output logic [frwm_pkg::STATUS_W-1:0] m_tuser,  // status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [frwm_pkg::SF_W-1:0]     cfg_data
);
    import frwm_pkg::*;

    localparam int ENTRY_W = 3 * TIME_W + FW;

    logic [SF_W-1:0]    sf_reg;
    logic               f_valid, f_ready, b_valid, b_ready;
    logic [ENTRY_W-1:0] f_data, b_data;
    logic [FPS_W-1:0]   fps;
    logic [FW-1:0]      held;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sf_reg <= SF_RESET;
        end else if (cfg_valid) begin
            sf_reg <= cfg_data;
        end
    end

    frwm_front #(
        .WINDOW  (WINDOW),
        .FW      (FW),
        .ENTRY_W (ENTRY_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .s_time   (s_tdata[TIME_W-1:0]),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_data   (f_data)
    );

    frwm_queue #(
        .W     (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    frwm_back #(
        .WINDOW  (WINDOW),
        .FW      (FW),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .stall_factor (sf_reg),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_data       (b_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_fps        (fps),
        .m_status     (m_tuser),
        .m_held       (held)
    );

    assign m_tdata = M_TDATA_W'({held, fps});

endmodule

// File: design/frwm_front.sv
// Front end: accepts items, keeps the timestamp ring and window counters,
// and turns each query into a snapshot for the queue. Uses frwm_pkg.
module frwm_front #(
    parameter int WINDOW  = frwm_pkg::WINDOW_DEF,
    parameter int FW      = $clog2(WINDOW + 1),
    parameter int ENTRY_W = 3 * frwm_pkg::TIME_W + FW
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_op,
    input  logic [frwm_pkg::TIME_W-1:0] s_time,
    output logic                        q_valid,
    input  logic                        q_ready,
    output logic [ENTRY_W-1:0]          q_data
);
    import frwm_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW = FW + 1;

    logic [TIME_W-1:0] ring_mem [WINDOW];

    logic [IW-1:0]     wr_idx_reg, wr_idx_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [TIME_W-1:0] rd_new_reg, rd_old_reg, t_reg;
    logic [FW-1:0]     snap_fill_reg;

    logic              accept, push;
    logic [IW-1:0]     new_idx, old_idx;
    logic [SW-1:0]     old_sum;

    assign push     = hold_valid_reg && q_ready;
    assign s_tready = !hold_valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    assign new_idx = (wr_idx_reg == '0) ? IW'(WINDOW - 1) : wr_idx_reg - IW'(1);

    always_comb begin
        old_sum = SW'(wr_idx_reg) + SW'(WINDOW) - SW'(fill_reg);
        if (old_sum >= SW'(WINDOW)) begin
            old_sum = old_sum - SW'(WINDOW);
        end
        old_idx = old_sum[IW-1:0];
    end

    always_comb begin
        wr_idx_next     = wr_idx_reg;
        fill_next       = fill_reg;
        hold_valid_next = hold_valid_reg;
        if (push) begin
            hold_valid_next = 1'b0;
        end
        if (accept) begin
            if (s_op == OP_RECORD) begin
                wr_idx_next = (wr_idx_reg == IW'(WINDOW - 1)) ? '0 : wr_idx_reg + IW'(1);
                if (fill_reg < FW'(WINDOW)) begin
                    fill_next = fill_reg + FW'(1);
                end
            end else begin
                hold_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg     <= '0;
            fill_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            wr_idx_reg     <= wr_idx_next;
            fill_reg       <= fill_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_op == OP_RECORD) begin
            ring_mem[wr_idx_reg] <= s_time;
        end
        if (accept && s_op == OP_QUERY) begin
            rd_new_reg    <= ring_mem[new_idx];
            rd_old_reg    <= ring_mem[old_idx];
            t_reg         <= s_time;
            snap_fill_reg <= fill_reg;
        end
    end

    assign q_valid = hold_valid_reg;
    assign q_data  = {snap_fill_reg, t_reg, rd_new_reg, rd_old_reg};

endmodule

// File: design/frwm_queue.sv
// Short queue between front and back end.
// No dependencies.
module frwm_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: design/frwm_back.sv
// Back end: classifies a query snapshot, runs the restoring divider and
// holds the result item. Uses frwm_pkg.
module frwm_back #(
    parameter int WINDOW  = frwm_pkg::WINDOW_DEF,
    parameter int FW      = $clog2(WINDOW + 1),
    parameter int ENTRY_W = 3 * frwm_pkg::TIME_W + FW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [frwm_pkg::SF_W-1:0]     stall_factor,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [ENTRY_W-1:0]            q_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [frwm_pkg::FPS_W-1:0]    m_fps,
    output logic [frwm_pkg::STATUS_W-1:0] m_status,
    output logic [FW-1:0]                 m_held
);
    import frwm_pkg::*;

    localparam int NUM_W  = NS_Q16_W + FW;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int PROD_W = TIME_W + SF_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    logic [TIME_W-1:0]   t_reg, new_reg, old_reg;
    logic [FW-1:0]       fill_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                nonpos_reg, short_reg;
    logic [TIME_W-1:0]   span_reg, gap_reg, dur_reg, div_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [FW-1:0]       frames_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [TIME_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [FPS_W-1:0]    fps_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FW-1:0]       out_held_reg;

    logic [TIME_W:0]     trial;
    logic                fit;
    logic [TIME_W-1:0]   gap_w;
    logic                out_free;

    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign fit      = trial >= {1'b0, div_reg};
    assign gap_w    = t_reg - new_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = state_reg == S_IDLE;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    state_next = (q_data[ENTRY_W-1 -: FW] < FW'(2)) ? S_DONE : S_EVAL;
                end
            end
            S_EVAL: state_next = S_SEL;
            S_SEL: begin
                if (nonpos_reg || (!short_reg && {{SF_W{1'b0}}, gap_reg} > prod_reg)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_DIV;
            S_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    {fill_reg, t_reg, new_reg, old_reg} <= q_data;
                    status_reg <= (q_data[ENTRY_W-1 -: FW] < FW'(2)) ? ST_FEW : ST_OK;
                end
            end
            S_EVAL: begin
                nonpos_reg <= new_reg <= old_reg;
                span_reg   <= new_reg - old_reg;
                gap_reg    <= gap_w;
                short_reg  <= (t_reg < new_reg) || (gap_w < (new_reg - old_reg));
                prod_reg   <= {{SF_W{1'b0}}, new_reg - old_reg}
                              * {{TIME_W{1'b0}}, stall_factor};
                dur_reg    <= t_reg - old_reg;
            end
            S_SEL: begin
                if (nonpos_reg) begin
                    status_reg <= ST_ZERO;
                end else if (short_reg) begin
                    frames_reg <= fill_reg - FW'(1);
                    div_reg    <= span_reg;
                end else if ({{SF_W{1'b0}}, gap_reg} > prod_reg) begin
                    status_reg <= ST_STALL;
                end else begin
                    frames_reg <= fill_reg;
                    div_reg    <= dur_reg;
                end
            end
            S_MUL: begin
                num_reg <= NUM_W'(frames_reg) * NUM_W'(NS_PER_S_Q16);
                rem_reg <= '0;
                cnt_reg <= CNT_W'(NUM_W - 1);
            end
            S_DIV: begin
                rem_reg <= fit ? TIME_W'(trial - {1'b0, div_reg}) : trial[TIME_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], fit};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    out_status_reg <= status_reg;
                    out_held_reg   <= fill_reg;
                    if (status_reg != ST_OK) begin
                        fps_reg <= '0;
                    end else if (|num_reg[NUM_W-1:FPS_W]) begin
                        fps_reg <= '1;
                    end else begin
                        fps_reg <= num_reg[FPS_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_fps    = fps_reg;
    assign m_status = out_status_reg;
    assign m_held   = out_held_reg;

endmodule

// File: verif/frwm_checker.sv
// Checker for the frame rate window meter: tracks the stamp window and the
// stall factor from the observed channels, predicts each query's result and
// compares. Depends on frwm_pkg.
`timescale 1ns / 1ps
module frwm_checker #(
    parameter int WINDOW    = frwm_pkg::WINDOW_DEF,
    parameter int M_TDATA_W = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [63:0]                   s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [M_TDATA_W-1:0]          m_tdata,
    input  logic [frwm_pkg::STATUS_W-1:0] m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [frwm_pkg::SF_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import frwm_pkg::*;

    localparam int FW = $clog2(WINDOW + 1);

    typedef struct packed {
        logic [FPS_W-1:0]    fps;
        logic [STATUS_W-1:0] status;
        logic [FW-1:0]       held;
    } rate_result_t;

    logic [TIME_W-1:0] stamps [WINDOW];
    int                wr_idx;
    int                fill;
    logic [SF_W-1:0]   stall_factor;
    rate_result_t      expected_rates [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void record_stamp(input logic [TIME_W-1:0] t);
        stamps[wr_idx] = t;
        wr_idx = (wr_idx + 1) % WINDOW;
        if (fill < WINDOW)
            fill++;
    endfunction

    // floor(frames * 1e9 * 2^16 / dur), saturated to 32 bits
    function automatic logic [FPS_W-1:0] q16_rate(input int frames, input logic [63:0] dur);
        logic [63:0] q;
        q = (64'(frames) * 64'(NS_PER_S_Q16)) / dur;
        return (q > 64'hFFFF_FFFF) ? '1 : q[FPS_W-1:0];
    endfunction

    function automatic rate_result_t rate_for_query(input logic [TIME_W-1:0] now);
        rate_result_t      r;
        logic [TIME_W-1:0] newest;
        logic [TIME_W-1:0] oldest;
        logic [TIME_W-1:0] span;
        logic [67:0]       stall_limit;
        r.fps    = '0;
        r.status = ST_OK;
        r.held   = FW'(fill);
        if (fill < 2) begin
            r.status = ST_FEW;
        end else begin
            newest = stamps[(wr_idx + WINDOW - 1) % WINDOW];
            oldest = stamps[(wr_idx + WINDOW - fill) % WINDOW];
            if (newest <= oldest) begin
                r.status = ST_ZERO;
            end else begin
                span        = newest - oldest;
                stall_limit = 68'(stall_factor) * 68'(span);
                if (now < newest || (now - newest) < span)
                    r.fps = q16_rate(fill - 1, 64'(span));
                else if (68'(now - newest) > stall_limit)
                    r.status = ST_STALL;
                else
                    r.fps = q16_rate(fill, 64'(now - oldest));
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        rate_result_t got;
        rate_result_t want;
        if (!aresetn) begin
            wr_idx       = 0;
            fill         = 0;
            stall_factor = SF_RESET;
            expected_rates.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                stall_factor = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_RECORD)
                    record_stamp(s_tdata[TIME_W-1:0]);
                else
                    expected_rates.push_back(rate_for_query(s_tdata[TIME_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                got.fps    = m_tdata[FPS_W-1:0];
                got.held   = m_tdata[FPS_W +: FW];
                got.status = m_tuser;
                if (expected_rates.size() == 0) begin
                    report("unexpected item", 64'(got), '0);
                end else begin
                    want = expected_rates.pop_front();
                    if (got.fps !== want.fps)
                        report("fps_q16", 64'(got.fps), 64'(want.fps));
                    if (got.status !== want.status)
                        report("status", 64'(got.status), 64'(want.status));
                    if (got.held !== want.held)
                        report("stamps_held", 64'(got.held), 64'(want.held));
                end
            end
        end
        pending = expected_rates.size();
    end

endmodule

// File: verif/frame_rate_window_meter_core_tb.sv
// Testbench top for frame_rate_window_meter_core: clock, reset, stamp and
// query stimulus, stall factor writes, watchdog and verdict.
// Depends on frwm_pkg, frame_rate_window_meter_core and frwm_checker.
`timescale 1ns / 1ps
module frame_rate_window_meter_core_tb;
    import frwm_pkg::*;

    localparam int M_TDATA_W      = 40;
    localparam int ITEMS          = 450;
    localparam int PHASES         = 5;
    localparam int SETTLE         = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SF_W-1:0]       cfg_data;

    int                fail_count;
    int                pending;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                sent_items;
    int                idle_cycles;
    logic [SF_W-1:0]   stall_factor;
    logic [TIME_W-1:0] last_stamp;

    frame_rate_window_meter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    frwm_checker #(
        .WINDOW    (WINDOW_DEF),
        .M_TDATA_W (M_TDATA_W)
    ) u_rate_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    task automatic send_item(input logic op, input logic [TIME_W-1:0] t);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(64 - TIME_W){1'b0}}, t};
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        if (op == OP_RECORD)
            last_stamp = t;
    endtask

    task automatic write_stall_factor(input logic [SF_W-1:0] value);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        // records carry no item out and never enter the queue; pending counts only queries
        repeat (SETTLE) @(negedge aclk);
        cfg_valid    = 1'b1;
        cfg_data     = value;
        stall_factor = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // query time placed against the expected span and the stall threshold
    task automatic send_query(input logic [TIME_W-1:0] span);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] stall_at;
        logic [63:0]       r;
        r        = {$urandom, $urandom};
        stall_at = span * stall_factor;
        case ($urandom_range(7))
            0: t = last_stamp - TIME_W'($urandom_range(1, 1000));
            1: t = last_stamp + ((span != 0) ? r[TIME_W-1:0] % span : '0);
            2: t = last_stamp + span;
            3: t = last_stamp + stall_at;
            4: t = last_stamp + stall_at + 1'b1;
            5: t = last_stamp + span + ((stall_at != 0) ? r[TIME_W-1:0] % stall_at : '0);
            6: t = last_stamp + (r[TIME_W-1:0] >> $urandom_range(61));
            default: t = last_stamp;
        endcase
        send_item(OP_QUERY, t);
    endtask

    task automatic send_noise();
        logic [63:0] r;
        r = {$urandom, $urandom};
        send_item($urandom_range(1) ? OP_QUERY : OP_RECORD,
                  r[TIME_W-1:0] >> ($urandom_range(3) == 0 ? $urandom_range(61) : 0));
    endtask

    // a run of frame stamps at a steady period, queries mixed in
    task automatic run_burst();
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] t;
        logic [63:0]       r;
        int                n;
        int                i;
        r    = {$urandom, $urandom};
        base = r[TIME_W-1:0] >> $urandom_range(61);
        r    = {$urandom, $urandom};
        case ($urandom_range(3))
            0: period = $urandom_range(1) ? TIME_W'(16_666_667) : TIME_W'(33_333_333);
            1: period = TIME_W'($urandom_range(1, 1000));
            2: period = TIME_W'($urandom);
            default: period = TIME_W'(r >> 28);
        endcase
        n = $urandom_range(2, 22);
        for (i = 0; i < n; i++) begin
            t = base + period * TIME_W'(i);
            if ($urandom_range(7) == 0)
                t = t + TIME_W'($urandom_range(3));
            if ($urandom_range(15) == 0)
                t = TIME_W'({$urandom, $urandom});
            send_item(OP_RECORD, t);
            if ($urandom_range(4) == 0)
                send_query(period * TIME_W'(i < WINDOW_DEF ? i : WINDOW_DEF - 1));
        end
        repeat ($urandom_range(1, 3))
            send_query(period * TIME_W'((n < WINDOW_DEF ? n : WINDOW_DEF) - 1));
    endtask

    task automatic run_directed();
        send_item(OP_QUERY, '0);
        send_item(OP_RECORD, TIME_W'(100));
        send_item(OP_QUERY, TIME_MAX);
        send_item(OP_RECORD, TIME_W'(50));
        send_item(OP_QUERY, TIME_W'(60));
        send_item(OP_RECORD, TIME_W'(100));
        send_item(OP_QUERY, TIME_W'(100));
        send_item(OP_RECORD, TIME_W'(101));
        send_item(OP_QUERY, TIME_W'(101));
        send_item(OP_QUERY, '0);
        send_item(OP_RECORD, TIME_W'(1100));
        send_item(OP_QUERY, TIME_W'(2100));
        send_item(OP_QUERY, TIME_W'(6100));
        send_item(OP_QUERY, TIME_W'(6101));
        send_item(OP_QUERY, TIME_MAX);
        send_item(OP_RECORD, TIME_MAX);
        send_item(OP_QUERY, TIME_MAX);
        send_item(OP_RECORD, '0);
        send_item(OP_QUERY, '0);
    endtask

    initial begin
        int ph;
        int start;
        int burst_no;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = '0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_items     = 0;
        idle_cycles    = 0;
        burst_no       = 0;
        stall_factor   = SF_RESET;
        last_stamp     = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        run_directed();

        for (ph = 0; ph < PHASES; ph++) begin
            set_idling(0);
            case (ph)
                0: write_stall_factor(4'd15);
                1: write_stall_factor(4'd0);
                2: write_stall_factor(4'd1);
                3: write_stall_factor(SF_W'($urandom_range(2, 14)));
                default: write_stall_factor(SF_RESET);
            endcase
            start = sent_items;
            while (sent_items - start < ITEMS / PHASES) begin
                set_idling(burst_no % 4);
                if ($urandom_range(6) == 0)
                    send_noise();
                else
                    run_burst();
                burst_no++;
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: frame_rate_window_meter_core.f
design/frwm_pkg.sv
design/frwm_front.sv
design/frwm_queue.sv
design/frwm_back.sv
design/frame_rate_window_meter_core.sv
verif/frwm_checker.sv
verif/frame_rate_window_meter_core_tb.sv
